// File: hdl/version_tag_extractor_top_assert.svh
// ----------------------------------------------------------------------------
// Version tag extractor assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VERSION_TAG_EXTRACTOR_TOP_ASSERT_SVH
`define VERSION_TAG_EXTRACTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define VTE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vte assertion failed");
`define VTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vte assertion failed");
`else
`define VTE_ASSERT_SAME(label, ante, cons)
`define VTE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/vte_pkg.sv
// ----------------------------------------------------------------------------
// vte_pkg
// Word types, phase encodings and character constants of the tag extractor.
// ----------------------------------------------------------------------------
package vte_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       last;
        logic       found;
    } out_word_t;

    typedef struct packed {
        logic      hit;
        out_word_t word;
    } scan_result_t;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'b001,
        PH_COPY   = 3'b010,
        PH_DONE   = 3'b100
    } scan_phase_t;

    typedef enum logic [2:0] {
        SH_SEEK = 3'b001,
        SH_NUM  = 3'b010,
        SH_END  = 3'b100
    } short_phase_t;

    localparam int unsigned TAG_LEN = 5;

    localparam logic [7:0] TAG_CHARS [TAG_LEN] = '{8'h24, 8'h56, 8'h45, 8'h52, 8'h3A};

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UPPER_V = 8'h56;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_LOWER_V = 8'h76;

endpackage

// File: hdl/vte_scan.sv
// ----------------------------------------------------------------------------
// vte_scan
// Tag match, copy and version-number tracking state; one byte per step.
// ----------------------------------------------------------------------------
module vte_scan #(
    parameter int unsigned MAX_VERSION_LEN = 127,
    parameter int unsigned MAX_SHORT_LEN   = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  vte_pkg::in_word_t     word,
    input  logic                  short_mode,
    output vte_pkg::scan_result_t result
);

    localparam int unsigned CW = $clog2(MAX_VERSION_LEN + 1);
    localparam int unsigned SW = $clog2(MAX_SHORT_LEN + 1);

    logic [2:0]            match_count_reg, match_count_next;
    vte_pkg::scan_phase_t  scan_phase_reg, scan_phase_next;
    logic [CW-1:0]         copied_count_reg, copied_count_next;
    vte_pkg::short_phase_t short_phase_reg, short_phase_next;
    logic [SW-1:0]         short_count_reg, short_count_next;
    logic [7:0]            previous_char_reg, previous_char_next;

    always_comb
    begin
        logic [7:0] c;
        logic       eov;
        logic       take;
        logic       emit;
        logic       fin;
        logic       fnd;
        logic       digit;
        logic       lead;
        logic       num_end;

        c    = word.data_byte;
        eov  = (c == vte_pkg::CH_NUL) || (c == vte_pkg::CH_LF) || (c == vte_pkg::CH_CR);
        take = 1'b0;
        emit = 1'b0;
        fin  = 1'b0;
        fnd  = 1'b0;
        digit = c inside {[vte_pkg::CH_ZERO:vte_pkg::CH_NINE]};
        lead  = previous_char_reg inside {vte_pkg::CH_NUL, vte_pkg::CH_SPACE,
                                          vte_pkg::CH_LOWER_V, vte_pkg::CH_UPPER_V};
        num_end = c inside {vte_pkg::CH_SPACE, vte_pkg::CH_LBRACK, vte_pkg::CH_GT,
                            vte_pkg::CH_RPAR, vte_pkg::CH_LF};

        match_count_next   = match_count_reg;
        scan_phase_next    = scan_phase_reg;
        copied_count_next  = copied_count_reg;
        short_phase_next   = short_phase_reg;
        short_count_next   = short_count_reg;
        previous_char_next = previous_char_reg;

        case (scan_phase_reg)
            vte_pkg::PH_SEARCH:
            begin
                if (match_count_reg < 3'(vte_pkg::TAG_LEN) &&
                    c == vte_pkg::TAG_CHARS[match_count_reg])
                begin
                    if (match_count_reg == 3'(vte_pkg::TAG_LEN - 1))
                    begin
                        match_count_next = '0;
                        scan_phase_next  = vte_pkg::PH_COPY;
                    end
                    else
                    begin
                        match_count_next = match_count_reg + 3'd1;
                    end
                end
                else if (c == vte_pkg::CH_DOLLAR)
                begin
                    match_count_next = 3'd1;
                end
                else
                begin
                    match_count_next = '0;
                end
            end
            vte_pkg::PH_COPY:
            begin
                if (!(copied_count_reg == '0 && c == vte_pkg::CH_SPACE))
                begin
                    if (!eov)
                    begin
                        if (short_phase_reg == vte_pkg::SH_SEEK && digit && lead)
                        begin
                            short_phase_next = vte_pkg::SH_NUM;
                            short_count_next = '0;
                        end
                        if (short_phase_next == vte_pkg::SH_NUM)
                        begin
                            if (num_end)
                            begin
                                short_phase_next = vte_pkg::SH_END;
                            end
                            else
                            begin
                                take = 1'b1;
                                short_count_next = short_count_next + 1'b1;
                                if (short_count_next >= SW'(MAX_SHORT_LEN))
                                begin
                                    short_phase_next = vte_pkg::SH_END;
                                end
                            end
                        end
                        previous_char_next = c;
                        copied_count_next  = copied_count_reg + 1'b1;
                        emit = short_mode ? take : 1'b1;
                    end
                    if (eov || copied_count_next >= CW'(MAX_VERSION_LEN))
                    begin
                        scan_phase_next = vte_pkg::PH_DONE;
                        fin = 1'b1;
                        fnd = short_mode ? (short_phase_next != vte_pkg::SH_SEEK) : 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (word.end_of_file)
        begin
            if (scan_phase_reg != vte_pkg::PH_DONE && !fin)
            begin
                fin = 1'b1;
                fnd = 1'b0;
            end
            match_count_next   = '0;
            scan_phase_next    = vte_pkg::PH_SEARCH;
            copied_count_next  = '0;
            short_phase_next   = vte_pkg::SH_SEEK;
            short_count_next   = '0;
            previous_char_next = '0;
        end

        result.hit             = emit || fin;
        result.word.out_char   = emit ? c : 8'h00;
        result.word.char_valid = emit;
        result.word.last       = fin;
        result.word.found      = fnd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_count_reg   <= '0;
            scan_phase_reg    <= vte_pkg::PH_SEARCH;
            copied_count_reg  <= '0;
            short_phase_reg   <= vte_pkg::SH_SEEK;
            short_count_reg   <= '0;
            previous_char_reg <= '0;
        end
        else if (step)
        begin
            match_count_reg   <= match_count_next;
            scan_phase_reg    <= scan_phase_next;
            copied_count_reg  <= copied_count_next;
            short_phase_reg   <= short_phase_next;
            short_count_reg   <= short_count_next;
            previous_char_reg <= previous_char_next;
        end
    end

endmodule

// File: hdl/version_tag_extractor_top.sv
// ----------------------------------------------------------------------------
// version_tag_extractor_top
// Scans a file byte stream for the "$VER:" tag and streams out the version.
// ----------------------------------------------------------------------------
// Input channel src_*: one file byte per word, end_of_file set on the last
// byte of each file. Output channel dst_*: one word per emitted character;
// last is set on the word that ends each file's result (found=0 means
// discard the characters already sent for that file). Bytes that yield
// nothing produce no output word.
// cfg_wr_en/cfg_wr_data write short_mode; change it only while idle.
// Throughput: one byte per cycle while src_stall is low. Each byte's result
// word reaches dst_* through a single output register.
// The scanner state is updated in the same cycle the byte is accepted.
// src_stall is raised only while the output register holds a word and
// dst_stall is high; a stalled output word holds steady.
// Reset clears the scanner, the output valid flag and short_mode; the output word is not reset.
// ----------------------------------------------------------------------------
`include "version_tag_extractor_top_assert.svh"

module version_tag_extractor_top #(
    parameter int unsigned MAX_VERSION_LEN = 127,
    parameter int unsigned MAX_SHORT_LEN   = 31
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  vte_pkg::in_word_t  src_word,
    output logic               dst_valid,
    input  logic               dst_stall,
    output vte_pkg::out_word_t dst_word,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data
);

    logic                  short_mode_reg;
    logic                  dst_valid_reg;
    vte_pkg::out_word_t    dst_word_reg;
    logic                  accept;
    vte_pkg::scan_result_t result;

    assign src_stall = dst_valid_reg && dst_stall;
    assign accept    = src_valid && !src_stall;

    vte_scan #(
        .MAX_VERSION_LEN (MAX_VERSION_LEN),
        .MAX_SHORT_LEN   (MAX_SHORT_LEN)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .word       (src_word),
        .short_mode (short_mode_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_mode_reg <= 1'b0;
            dst_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                short_mode_reg <= cfg_wr_data;
            end
            if (accept && result.hit)
            begin
                dst_valid_reg <= 1'b1;
            end
            else if (!dst_stall)
            begin
                dst_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && result.hit)
        begin
            dst_word_reg <= result.word;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_word  = dst_word_reg;

    `VTE_ASSERT_SAME(a_found_with_last, dst_valid && dst_word.found, dst_word.last)
    `VTE_ASSERT_SAME(a_word_has_content, dst_valid && !dst_word.char_valid, dst_word.last)
    `VTE_ASSERT_SAME(a_empty_char_zero, dst_valid && !dst_word.char_valid,
                     dst_word.out_char == 8'h00)
    `VTE_ASSERT_NEXT(a_stall_keeps_word, src_stall, dst_valid)

endmodule
